// ===== rtl/core/fps_pkg.sv =====
package fps_pkg;

	// Default stack depth in words.
	localparam int unsigned DEPTH_DEF = 1024;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned CMD_W    = 3;
	localparam int unsigned OFFSET_W = 11;
	localparam int unsigned COUNT_W  = 11;
	localparam int unsigned REL_W    = 12;
	localparam int unsigned FRAME_W  = 10;
	localparam int unsigned STATUS_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH       = 3'd0,
		CMD_POP        = 3'd1,
		CMD_PUSH_REP   = 3'd2,
		CMD_POP_REP    = 3'd3,
		CMD_PUSH_FRAME = 3'd4,
		CMD_POP_FRAME  = 3'd5,
		CMD_LOAD       = 3'd6,
		CMD_STORE      = 3'd7
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_OVER  = 2'd1,
		ST_UNDER = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic rd_issue;
		logic fill_step;
		logic commit;
		logic fill_end;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_read;
		logic need_fill;
		logic fill_done;
		logic out_free;
	} ctl_sts_t;

endpackage

// ===== rtl/core/fps_ifs.sv =====
interface fps_req_if;
	logic                                valid;
	logic                                ready;
	logic [fps_pkg::CMD_W-1:0]           command;
	logic signed [fps_pkg::WORD_W-1:0]   value;
	logic signed [fps_pkg::OFFSET_W-1:0] offset;
	logic [fps_pkg::COUNT_W-1:0]         count;

	modport source(output valid, command, value, offset, count, input ready);
	modport sink(input valid, command, value, offset, count, output ready);
endinterface

interface fps_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [fps_pkg::WORD_W-1:0]  read_value;
	logic signed [fps_pkg::REL_W-1:0]   push_offset;
	logic [fps_pkg::FRAME_W-1:0]        frame_index;
	logic signed [fps_pkg::REL_W-1:0]   next_address;
	logic [fps_pkg::STATUS_W-1:0]       status;

	modport source(output valid, read_value, push_offset, frame_index, next_address, status,
		input ready);
	modport sink(input valid, read_value, push_offset, frame_index, next_address, status,
		output ready);
endinterface

// ===== rtl/core/fps_ram.sv =====
module fps_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/fps_ctrl.sv =====
module fps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  fps_pkg::ctl_sts_t sts,
	output fps_pkg::ctl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FILL,
		S_RDWAIT
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   ready_q;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid && ready_q) begin
					cmd.latch = 1'b1;
					state_nx  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.need_read) begin
					cmd.rd_issue = 1'b1;
					state_nx     = S_RDWAIT;
				end else if (sts.need_fill) begin
					state_nx = S_FILL;
				end else if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			S_FILL: begin
				if (!sts.fill_done) begin
					cmd.fill_step = 1'b1;
				end else if (sts.out_free) begin
					cmd.fill_end = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			S_RDWAIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_nx;
			ready_q <= (state_nx == S_IDLE);
		end
	end

	assign req_ready = ready_q;

endmodule

// ===== rtl/core/fps_dp.sv =====
module fps_dp #(
	parameter int unsigned DEPTH = fps_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fps_pkg::ctl_cmd_t                   cmd,
	output fps_pkg::ctl_sts_t                   sts,
	input  logic [fps_pkg::CMD_W-1:0]           req_command,
	input  logic signed [fps_pkg::WORD_W-1:0]   req_value,
	input  logic signed [fps_pkg::OFFSET_W-1:0] req_offset,
	input  logic [fps_pkg::COUNT_W-1:0]         req_count,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic signed [fps_pkg::WORD_W-1:0]   rsp_read_value,
	output logic signed [fps_pkg::REL_W-1:0]    rsp_push_offset,
	output logic [fps_pkg::FRAME_W-1:0]         rsp_frame_index,
	output logic signed [fps_pkg::REL_W-1:0]    rsp_next_address,
	output logic [fps_pkg::STATUS_W-1:0]        rsp_status
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	// Signed width that holds depth, frame pointer and offset sums.
	localparam int unsigned DW = ((CW > fps_pkg::OFFSET_W) ? CW : fps_pkg::OFFSET_W) + 2;
	localparam int unsigned WW = fps_pkg::WORD_W;

	// Latched command word.
	fps_pkg::cmd_t                     cmd_q;
	logic [WW-1:0]                     val_q;
	logic signed [fps_pkg::OFFSET_W-1:0] off_q;
	logic [fps_pkg::COUNT_W-1:0]       cnt_q;
	logic [fps_pkg::COUNT_W-1:0]       rem_q;

	// Architectural state.
	logic [CW-1:0] depth_q;
	logic [AW-1:0] fp_q;

	// Result register.
	logic                               out_valid_q;
	logic [WW-1:0]                      out_rd_q;
	logic [fps_pkg::REL_W-1:0]          out_poff_q;
	logic [fps_pkg::FRAME_W-1:0]        out_fidx_q;
	logic [fps_pkg::REL_W-1:0]          out_naddr_q;
	fps_pkg::status_t                   out_st_q;

	logic signed [DW-1:0] depth_s;
	logic signed [DW-1:0] fp_s;
	logic signed [DW-1:0] addr_s;
	logic [CW-1:0]        depth_dec;
	logic                 full;
	logic                 empty;
	logic                 rep_over;
	logic                 rep_under;
	logic                 addr_bad;
	logic                 saved_bad;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WW-1:0]        mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic [WW-1:0]        mem_rdata;

	logic [CW-1:0]        depth_nx;
	logic [AW-1:0]        fp_nx;
	logic [WW-1:0]        rd_nx;
	logic [fps_pkg::REL_W-1:0] poff_nx;
	fps_pkg::status_t     st_nx;
	logic                 commit_we;
	logic [AW-1:0]        commit_waddr;
	logic [WW-1:0]        commit_wdata;

	assign depth_s   = $signed(DW'(depth_q));
	assign fp_s      = $signed(DW'(fp_q));
	assign addr_s    = fp_s + DW'(off_q);
	assign depth_dec = depth_q - CW'(1);
	assign full      = (depth_q >= CW'(DEPTH));
	assign empty     = (depth_q == '0);
	assign rep_over  = (DW'(depth_q) + DW'(cnt_q)) > DW'(DEPTH);
	assign rep_under = DW'(cnt_q) > DW'(depth_q);
	assign addr_bad  = (addr_s < 0) || (addr_s >= depth_s);
	assign saved_bad = mem_rdata[WW-1] || (mem_rdata[WW-2:0] >= (WW-1)'(DEPTH));

	assign sts.need_read = ((cmd_q == fps_pkg::CMD_POP) && !empty)
		|| ((cmd_q == fps_pkg::CMD_POP_FRAME) && !empty)
		|| ((cmd_q == fps_pkg::CMD_LOAD) && !addr_bad);
	assign sts.need_fill = (cmd_q == fps_pkg::CMD_PUSH_REP) && !rep_over && (cnt_q != '0);
	assign sts.fill_done = (rem_q == '0);
	assign sts.out_free  = !out_valid_q || rsp_ready;

	// Outcome of the latched command given the current state and read data.
	always_comb begin
		depth_nx     = depth_q;
		fp_nx        = fp_q;
		rd_nx        = '0;
		poff_nx      = '0;
		st_nx        = fps_pkg::ST_OK;
		commit_we    = 1'b0;
		commit_waddr = depth_q[AW-1:0];
		commit_wdata = val_q;
		if (cmd.fill_end) begin
			poff_nx = fps_pkg::REL_W'(depth_s - fp_s - DW'(1));
		end else begin
			case (cmd_q)
				fps_pkg::CMD_PUSH: begin
					if (full) begin
						st_nx = fps_pkg::ST_OVER;
					end else begin
						commit_we = 1'b1;
						depth_nx  = depth_q + CW'(1);
						poff_nx   = fps_pkg::REL_W'(depth_s - fp_s);
					end
				end
				fps_pkg::CMD_POP: begin
					if (empty) begin
						st_nx = fps_pkg::ST_UNDER;
					end else begin
						rd_nx    = mem_rdata;
						depth_nx = depth_dec;
					end
				end
				fps_pkg::CMD_PUSH_REP: begin
					if (rep_over) begin
						st_nx = fps_pkg::ST_OVER;
					end
				end
				fps_pkg::CMD_POP_REP: begin
					if (rep_under) begin
						st_nx = fps_pkg::ST_UNDER;
					end else begin
						depth_nx = depth_q - CW'(cnt_q);
					end
				end
				fps_pkg::CMD_PUSH_FRAME: begin
					if (full) begin
						st_nx = fps_pkg::ST_OVER;
					end else begin
						commit_we    = 1'b1;
						commit_wdata = WW'(fp_q);
						depth_nx     = depth_q + CW'(1);
						fp_nx        = depth_q[AW-1:0];
					end
				end
				fps_pkg::CMD_POP_FRAME: begin
					if (empty) begin
						st_nx = fps_pkg::ST_UNDER;
					end else if (saved_bad) begin
						st_nx = fps_pkg::ST_RANGE;
					end else begin
						rd_nx    = mem_rdata;
						depth_nx = depth_dec;
						fp_nx    = mem_rdata[AW-1:0];
					end
				end
				fps_pkg::CMD_LOAD: begin
					if (addr_bad) begin
						st_nx = fps_pkg::ST_RANGE;
					end else begin
						rd_nx = mem_rdata;
					end
				end
				fps_pkg::CMD_STORE: begin
					if (addr_bad) begin
						st_nx = fps_pkg::ST_RANGE;
					end else begin
						commit_we    = 1'b1;
						commit_waddr = addr_s[AW-1:0];
					end
				end
				default: begin
					st_nx = fps_pkg::ST_OK;
				end
			endcase
		end
	end

	// A repeated push writes one word per cycle at the top.
	assign mem_we    = cmd.fill_step || (cmd.commit && commit_we);
	assign mem_waddr = cmd.fill_step ? depth_q[AW-1:0] : commit_waddr;
	assign mem_wdata = cmd.fill_step ? val_q : commit_wdata;
	assign mem_raddr = (cmd_q == fps_pkg::CMD_LOAD) ? addr_s[AW-1:0] : depth_dec[AW-1:0];

	fps_ram #(
		.WIDTH (WW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (cmd.rd_issue),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q <= fps_pkg::cmd_t'(req_command);
			val_q <= req_value;
			off_q <= req_offset;
			cnt_q <= req_count;
		end
		if (cmd.commit || cmd.fill_end) begin
			out_rd_q    <= rd_nx;
			out_poff_q  <= poff_nx;
			out_fidx_q  <= fps_pkg::FRAME_W'(fp_nx);
			out_naddr_q <= fps_pkg::REL_W'($signed(DW'(depth_nx)) - $signed(DW'(fp_nx)));
			out_st_q    <= st_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			fp_q        <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.latch) begin
				rem_q <= req_count;
			end else if (cmd.fill_step) begin
				rem_q <= rem_q - fps_pkg::COUNT_W'(1);
			end
			if (cmd.fill_step) begin
				depth_q <= depth_q + CW'(1);
			end else if (cmd.commit) begin
				depth_q <= depth_nx;
				fp_q    <= fp_nx;
			end
			if (cmd.commit || cmd.fill_end) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid        = out_valid_q;
	assign rsp_read_value   = $signed(out_rd_q);
	assign rsp_push_offset  = $signed(out_poff_q);
	assign rsp_frame_index  = out_fidx_q;
	assign rsp_next_address = $signed(out_naddr_q);
	assign rsp_status       = out_st_q;

endmodule

// ===== rtl/core/frame_pointer_stack_unit.sv =====
// Call stack of signed 32-bit words with a stack pointer and a frame pointer, for an
// interpreter runtime. Each request word carries one command (push, pop, push repeat,
// pop repeat, push frame, pop frame, load or store at frame pointer plus offset) and
// yields exactly one response word with the popped or loaded value, the push offset,
// the frame pointer, the next free frame-relative address and a status code. The stack
// holds DEPTH words; overflow, underflow and out-of-range addresses are reported and
// change nothing. Items are handled one at a time. After the request is accepted, push,
// push frame, pop repeat, store and every command rejected at decode load the response
// register from the decode state; pop, pop frame and load otherwise first do a
// registered read of the stack memory and load it from the read-wait state, and a pop
// frame whose saved frame pointer is out of range is rejected only after that read;
// push repeat with a nonzero count that fits writes one word at a time through the
// single write port and then reports from the fill state. The next request is accepted
// at the edge after the previous one has been placed in the response register, even if
// that response is still waiting to be taken. A response that is not taken holds back
// the result of the next command until it is. The stack memory is not cleared after
// reset, so there is no initialization pass: only words that were written are read.
module frame_pointer_stack_unit #(
	parameter int unsigned DEPTH = fps_pkg::DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	fps_req_if.sink   req,
	fps_rsp_if.source rsp
);

	// The controller sequences each command; the datapath holds the stack pointer,
	// frame pointer, memory and response register.
	fps_pkg::ctl_cmd_t ctl_cmd;
	fps_pkg::ctl_sts_t ctl_sts;

	fps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (ctl_sts),
		.cmd       (ctl_cmd)
	);

	fps_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (ctl_cmd),
		.sts              (ctl_sts),
		.req_command      (req.command),
		.req_value        (req.value),
		.req_offset       (req.offset),
		.req_count        (req.count),
		.rsp_valid        (rsp.valid),
		.rsp_ready        (rsp.ready),
		.rsp_read_value   (rsp.read_value),
		.rsp_push_offset  (rsp.push_offset),
		.rsp_frame_index  (rsp.frame_index),
		.rsp_next_address (rsp.next_address),
		.rsp_status       (rsp.status)
	);

endmodule

// ===== rtl/core/fps_chk.sv =====
module fps_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic signed [fps_pkg::WORD_W-1:0]   rsp_read_value,
	input logic signed [fps_pkg::REL_W-1:0]    rsp_push_offset,
	input logic [fps_pkg::STATUS_W-1:0]        rsp_status
);

	// One command is in flight at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while another command is in flight");

	// A rejected command returns no data and no push offset.
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_status != fps_pkg::ST_OK))
		|-> ((rsp_read_value == '0) && (rsp_push_offset == '0)))
		else $error("rejected command returned data");

	// A new response only appears at the end of a command that was in flight.
	a_rsp_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response appeared with no command in flight");

	// A stalled response holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready)
		|=> (rsp_valid && $stable(rsp_read_value) && $stable(rsp_status)))
		else $error("stalled response changed");

endmodule

bind frame_pointer_stack_unit fps_chk u_fps_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_read_value  (rsp.read_value),
	.rsp_push_offset (rsp.push_offset),
	.rsp_status      (rsp.status)
);
